FILE: design/mbrtu_pkg.sv
// ----------------------------------------------------------------------------
// mbrtu_pkg: shared types and constants of the modbus rtu framer
// receiver and transmitter mode codes, input function codes, event codes,
// the result record and the modbus crc-16 byte update
// ----------------------------------------------------------------------------
package mbrtu_pkg;

  // input function codes
  localparam logic [1:0] FUNC_RX_BYTE  = 2'd0;
  localparam logic [1:0] FUNC_T35      = 2'd1;
  localparam logic [1:0] FUNC_TX_START = 2'd2;
  localparam logic [1:0] FUNC_TX_BYTE  = 2'd3;

  // receiver modes
  localparam logic [1:0] RX_INIT  = 2'd0;
  localparam logic [1:0] RX_IDLE  = 2'd1;
  localparam logic [1:0] RX_RCV   = 2'd2;
  localparam logic [1:0] RX_ERROR = 2'd3;

  // transmitter modes
  localparam logic [1:0] TX_IDLE = 2'd0;
  localparam logic [1:0] TX_XMIT = 2'd1;
  localparam logic [1:0] TX_END  = 2'd2;

  // receive events
  localparam logic [1:0] RXE_NONE  = 2'd0;
  localparam logic [1:0] RXE_READY = 2'd1;
  localparam logic [1:0] RXE_FRAME = 2'd2;

  // transmit events
  localparam logic [1:0] TXE_NONE    = 2'd0;
  localparam logic [1:0] TXE_SENT    = 2'd1;
  localparam logic [1:0] TXE_DONE    = 2'd2;
  localparam logic [1:0] TXE_REFUSED = 2'd3;

  // timer commands
  localparam logic [1:0] TMR_NONE    = 2'd0;
  localparam logic [1:0] TMR_RESTART = 2'd1;
  localparam logic [1:0] TMR_STOP    = 2'd2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // one result item
  typedef struct packed {
    logic [7:0] line_byte;
    logic       line_valid;
    logic [7:0] stored_byte;
    logic [7:0] store_index;
    logic       store_valid;
    logic [1:0] rx_event;
    logic       frame_ok;
    logic [7:0] slave_address;
    logic [7:0] pdu_length;
    logic [1:0] tx_event;
    logic [1:0] timer_cmd;
    logic       last;
  } res_t;

  // framer state other than the receive byte count
  typedef struct packed {
    logic [1:0]  rx_mode;
    logic [15:0] rx_crc;
    logic [7:0]  rx_first_byte;
    logic [1:0]  tx_mode;
    logic [15:0] tx_crc;
  } st_t;

  // reflected crc-16 update with one byte, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: design/mbrtu_step.sv
// ----------------------------------------------------------------------------
// mbrtu_step: framer next-state and result logic
// from the current state and one input item, computes the next state and
// the one or three result items that the item causes
// ----------------------------------------------------------------------------
module mbrtu_step #(
  parameter int MAX_FRAME = 256,
  parameter int CW        = 9
) (
  input  mbrtu_pkg::st_t   st,
  input  logic [CW-1:0]    rx_count,
  input  logic [1:0]       func,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  output mbrtu_pkg::st_t   st_nxt,
  output logic [CW-1:0]    rx_count_nxt,
  output mbrtu_pkg::res_t  res [3],
  output logic [1:0]       res_num
);

  logic [15:0]   rx_crc_upd;
  logic [15:0]   tx_crc_upd;
  logic [15:0]   start_crc;
  logic [CW-1:0] len_w;
  logic          long_enough;

  // crc of the incoming byte on both sides
  assign rx_crc_upd  = mbrtu_pkg::crc_byte(st.rx_crc, data_byte);
  assign tx_crc_upd  = mbrtu_pkg::crc_byte(st.tx_crc, data_byte);
  assign start_crc   = mbrtu_pkg::crc_byte(mbrtu_pkg::CRC_INIT, data_byte);
  assign long_enough = rx_count >= CW'(4);
  assign len_w       = rx_count - CW'(3);

  // per-function behavior
  always_comb begin
    st_nxt       = st;
    rx_count_nxt = rx_count;
    res[0]       = '0;
    res[1]       = '0;
    res[2]       = '0;
    res_num      = 2'd1;

    case (func)
      mbrtu_pkg::FUNC_RX_BYTE: begin
        res[0].timer_cmd = mbrtu_pkg::TMR_RESTART;
        if (st.rx_mode == mbrtu_pkg::RX_IDLE) begin
          rx_count_nxt         = CW'(1);
          st_nxt.rx_crc        = start_crc;
          st_nxt.rx_first_byte = data_byte;
          st_nxt.rx_mode       = mbrtu_pkg::RX_RCV;
          res[0].stored_byte   = data_byte;
          res[0].store_index   = 8'd0;
          res[0].store_valid   = 1'b1;
        end else if (st.rx_mode == mbrtu_pkg::RX_RCV) begin
          if (rx_count < CW'(MAX_FRAME)) begin
            res[0].stored_byte = data_byte;
            res[0].store_index = 8'(rx_count);
            res[0].store_valid = 1'b1;
            st_nxt.rx_crc      = rx_crc_upd;
            rx_count_nxt       = rx_count + CW'(1);
          end else begin
            st_nxt.rx_mode = mbrtu_pkg::RX_ERROR;
          end
        end
      end

      mbrtu_pkg::FUNC_T35: begin
        if (st.rx_mode == mbrtu_pkg::RX_INIT) begin
          res[0].rx_event = mbrtu_pkg::RXE_READY;
        end else if (st.rx_mode == mbrtu_pkg::RX_RCV) begin
          res[0].rx_event      = mbrtu_pkg::RXE_FRAME;
          res[0].frame_ok      = long_enough && (st.rx_crc == 16'h0000);
          res[0].slave_address = st.rx_first_byte;
          res[0].pdu_length    = long_enough ? 8'(len_w) : 8'd0;
        end
        if (st.tx_mode == mbrtu_pkg::TX_END) begin
          res[0].tx_event = mbrtu_pkg::TXE_DONE;
          st_nxt.tx_mode  = mbrtu_pkg::TX_IDLE;
        end
        res[0].timer_cmd = mbrtu_pkg::TMR_STOP;
        st_nxt.rx_mode   = mbrtu_pkg::RX_IDLE;
      end

      mbrtu_pkg::FUNC_TX_START: begin
        if (st.rx_mode != mbrtu_pkg::RX_IDLE) begin
          res[0].tx_event = mbrtu_pkg::TXE_REFUSED;
        end else begin
          st_nxt.tx_crc     = start_crc;
          st_nxt.tx_mode    = mbrtu_pkg::TX_XMIT;
          res[0].line_byte  = data_byte;
          res[0].line_valid = 1'b1;
        end
      end

      default: begin
        if (st.tx_mode == mbrtu_pkg::TX_XMIT) begin
          st_nxt.tx_crc     = tx_crc_upd;
          res[0].line_byte  = data_byte;
          res[0].line_valid = 1'b1;
          // final pdu byte: append crc low then high byte
          if (last_byte) begin
            res[1].line_byte  = tx_crc_upd[7:0];
            res[1].line_valid = 1'b1;
            res[2].line_byte  = tx_crc_upd[15:8];
            res[2].line_valid = 1'b1;
            res[2].tx_event   = mbrtu_pkg::TXE_SENT;
            res[2].timer_cmd  = mbrtu_pkg::TMR_RESTART;
            st_nxt.tx_mode    = mbrtu_pkg::TX_END;
            res_num           = 2'd3;
          end
        end
      end
    endcase

    // mark the final result of this item
    if (res_num == 2'd3) begin
      res[2].last = 1'b1;
    end else begin
      res[0].last = 1'b1;
    end
  end

endmodule

FILE: design/modbus_rtu_framer.sv
// ----------------------------------------------------------------------------
// modbus_rtu_framer: modbus rtu line framer with crc-16
// An item is taken in the cycle it is offered if the result register is empty
// or is handing over its final result in that cycle; its one or three results
// are computed in that same cycle and leave one per cycle from the result
// register while out_ready is high. Items that give one result therefore flow
// at one per cycle while out_ready is high; the final pdu byte of a transmit
// frame gives three results (byte, crc low, crc high) and holds the input until
// the crc high result is handed over. Received bytes are written out through
// the store_* fields; the frame store itself is outside.
module modbus_rtu_framer #(
  parameter int MAX_FRAME = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_line_byte,
  output logic       out_line_valid,
  output logic [7:0] out_stored_byte,
  output logic [7:0] out_store_index,
  output logic       out_store_valid,
  output logic [1:0] out_rx_event,
  output logic       out_frame_ok,
  output logic [7:0] out_slave_address,
  output logic [7:0] out_pdu_length,
  output logic [1:0] out_tx_event,
  output logic [1:0] out_timer_cmd,
  output logic       out_last
);

  localparam int CW = $clog2(MAX_FRAME + 1);

  mbrtu_pkg::st_t  st_r, st_nxt;
  logic [CW-1:0]   rx_count_r, rx_count_nxt;
  mbrtu_pkg::res_t res_r [3];
  mbrtu_pkg::res_t step_res [3];
  logic [1:0]      step_num;
  logic [1:0]      pend_r;
  logic [1:0]      rd_r;
  logic            in_xfer;
  logic            out_xfer;
  mbrtu_pkg::res_t cur;

  // handshakes
  assign out_valid = pend_r != 2'd0;
  assign out_xfer  = out_valid && out_ready;
  assign in_ready  = (pend_r == 2'd0) || ((pend_r == 2'd1) && out_ready);
  assign in_xfer   = in_valid && in_ready;

  // next state and results of the offered item
  mbrtu_step #(
    .MAX_FRAME (MAX_FRAME),
    .CW        (CW)
  ) u_step (
    .st           (st_r),
    .rx_count     (rx_count_r),
    .func         (in_func),
    .data_byte    (in_data_byte),
    .last_byte    (in_last_byte),
    .st_nxt       (st_nxt),
    .rx_count_nxt (rx_count_nxt),
    .res          (step_res),
    .res_num      (step_num)
  );

  // framer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.rx_mode       <= mbrtu_pkg::RX_INIT;
      st_r.rx_crc        <= mbrtu_pkg::CRC_INIT;
      st_r.rx_first_byte <= 8'd0;
      st_r.tx_mode       <= mbrtu_pkg::TX_IDLE;
      st_r.tx_crc        <= mbrtu_pkg::CRC_INIT;
      rx_count_r         <= '0;
    end else if (in_xfer) begin
      st_r       <= st_nxt;
      rx_count_r <= rx_count_nxt;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      rd_r   <= 2'd0;
    end else if (in_xfer) begin
      pend_r <= step_num;
      rd_r   <= 2'd0;
    end else if (out_xfer) begin
      pend_r <= pend_r - 2'd1;
      rd_r   <= rd_r + 2'd1;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r[0] <= step_res[0];
      res_r[1] <= step_res[1];
      res_r[2] <= step_res[2];
    end
  end

  // result selection
  always_comb begin
    case (rd_r)
      2'd0:    cur = res_r[0];
      2'd1:    cur = res_r[1];
      2'd2:    cur = res_r[2];
      default: cur = res_r[0];
    endcase
  end

  assign out_line_byte     = cur.line_byte;
  assign out_line_valid    = cur.line_valid;
  assign out_stored_byte   = cur.stored_byte;
  assign out_store_index   = cur.store_index;
  assign out_store_valid   = cur.store_valid;
  assign out_rx_event      = cur.rx_event;
  assign out_frame_ok      = cur.frame_ok;
  assign out_slave_address = cur.slave_address;
  assign out_pdu_length    = cur.pdu_length;
  assign out_tx_event      = cur.tx_event;
  assign out_timer_cmd     = cur.timer_cmd;
  assign out_last          = cur.last;

`ifndef SYNTH
  // read pointer and pending count stay within the three result slots
  a_slots: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, rd_r} + {1'b0, pend_r}) <= 3'd3)
    else $error("result slot overrun");

  // receive count never passes the frame limit
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    rx_count_r <= CW'(MAX_FRAME))
    else $error("receive count past frame limit");

  // the last flag marks exactly the final pending result
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (pend_r == 2'd1)))
    else $error("last flag out of place");

  // no new item while two or more results wait
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r >= 2'd2) |-> !in_ready)
    else $error("item taken over pending results");

  // once a three-result item is taken, all three results wait and the first carries a line byte
  a_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (step_num == 2'd3)) |=> (pend_r == 2'd3) && out_line_valid)
    else $error("crc trailer not queued");
`endif

endmodule
